// ===== sv/table_extract_min_fill_last_unit_defines.svh =====
// Assertion macros for the table extract-min unit.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef TABLE_EXTRACT_MIN_FILL_LAST_UNIT_DEFINES_SVH
`define TABLE_EXTRACT_MIN_FILL_LAST_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tem_pkg.sv =====
// Shared types and constants for the table extract-min unit.
// No dependencies; used by the top level, the controller and the datapath.
package tem_pkg;

  // Table size and derived widths.
  localparam int DEPTH   = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 6;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Operation codes carried on the input tuser.
  localparam logic FN_APPEND  = 1'b0;
  localparam logic FN_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;     // store the input value and report ok
    logic rep_full;   // report a full table
    logic rep_empty;  // report an empty table
    logic scan_start; // reset the read address for a scan
    logic rd_en;      // issue one table read
    logic finish;     // move the last entry, shrink count, report minimum
  } tem_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_end;   // current read address is the last held entry
  } tem_sts_t;

endpackage

// ===== sv/table_extract_min_fill_last_unit.sv =====
// Top level of the table extract-min unit: controller plus datapath.
// Depends on tem_pkg, tem_ctrl, tem_dp and the assertion macro header.
//
//   channel  | direction | tdata                              | tuser
//   ---------+-----------+------------------------------------+-------------
//   in_      | slave     | [31:0] value                       | [0] func
//   out_     | master    | [31:0] min_value, [37:32] count    | [1:0] status
//
// Append, append on a full table and extract on an empty table register
// their result at the edge that accepts the item.
// Extract walks the table through the one read port of the table RAM,
// one entry per cycle, then passes the drain and finish states.
// Reset clears the fill count and control state; table contents are kept.
// A finished result waits in the output register; a scan that ends while
// it is still held stalls before the write-back until it is taken.
`include "table_extract_min_fill_last_unit_defines.svh"

module table_extract_min_fill_last_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] min_value, [37:32] count, zero above
  output logic [1:0]  out_tuser   // [1:0] status
);

  tem_pkg::tem_cmd_t cmd;
  tem_pkg::tem_sts_t sts;
  logic [31:0]       min_value;
  logic [1:0]        status;
  tem_pkg::count_t   count;
  logic              full_report;
  logic              full_count_ok;

  tem_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .func       (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tem_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .value     (in_tdata),
    .min_value (min_value),
    .status    (status),
    .count     (count)
  );

  // Pack the result item.
  assign out_tdata = {2'b00, count, min_value};
  assign out_tuser = status;

  // Terms for the full-report check.
  assign full_report   = out_tvalid && (out_tuser == tem_pkg::ST_FULL);
  assign full_count_ok = (count == tem_pkg::count_t'(tem_pkg::DEPTH));

  // No new item is taken while the table is being scanned.
  `TEM_ASSERT_NOW(a_no_accept_in_scan, cmd.rd_en, !in_tready, "input accepted during scan")
  // Write-back only ever happens on a non-empty table.
  `TEM_ASSERT_NOW(a_finish_not_empty, cmd.finish, !sts.empty, "finish on empty table")
  // A full report always carries a count equal to the table depth.
  `TEM_ASSERT_NOW(a_full_count, full_report, full_count_ok, "full status with wrong count")
  // A scan start is followed by a read of the table.
  `TEM_ASSERT_NEXT(a_scan_follows, cmd.scan_start, cmd.rd_en, "scan did not start")

endmodule

// ===== sv/tem_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tem_ctrl.sv =====
// Controller state machine for the table extract-min unit.
// Depends on tem_pkg; drives the datapath through tem_cmd_t.
module tem_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              func,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tem_pkg::tem_sts_t sts,
  output tem_pkg::tem_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // The result register can take a new item when empty or being drained.
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign out_tvalid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (func == tem_pkg::FN_EXTRACT) begin
            if (sts.empty) begin
              cmd.rep_empty = 1'b1;
              out_valid_nxt = 1'b1;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end else begin
            if (sts.full) begin
              cmd.rep_full = 1'b1;
            end else begin
              cmd.append = 1'b1;
            end
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/tem_dp.sv =====
// Datapath for the table extract-min unit: table RAM, fill count, scan
// registers and result payload. Depends on tem_pkg and tem_ram.
module tem_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tem_pkg::tem_cmd_t            cmd,
  output tem_pkg::tem_sts_t            sts,
  input  logic [tem_pkg::DATA_W-1:0]   value,
  output logic [tem_pkg::DATA_W-1:0]   min_value,
  output logic [1:0]                   status,
  output tem_pkg::count_t              count
);

  tem_pkg::fill_t  fill_r, fill_nxt;
  tem_pkg::addr_t  rd_addr_r;
  tem_pkg::addr_t  last_idx;
  tem_pkg::addr_t  cmp_idx_r;
  logic            cmp_valid_r;
  logic signed [tem_pkg::DATA_W-1:0] rd_data;
  logic signed [tem_pkg::DATA_W-1:0] min_r;
  tem_pkg::addr_t  pos_r;
  logic [tem_pkg::DATA_W-1:0] last_val_r;
  logic            ram_we;
  tem_pkg::addr_t  ram_waddr;
  logic [tem_pkg::DATA_W-1:0] ram_wdata;
  logic [tem_pkg::DATA_W-1:0] min_value_r;
  logic [1:0]      status_r;
  tem_pkg::count_t count_r;

  assign last_idx     = tem_pkg::addr_t'(fill_r - tem_pkg::fill_t'(1));
  assign sts.full     = (fill_r == tem_pkg::fill_t'(tem_pkg::DEPTH));
  assign sts.empty    = (fill_r == '0);
  assign sts.scan_end = (rd_addr_r == last_idx);

  // Write port: append at the end, or move the last entry into the hole.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tem_pkg::addr_t'(fill_r);
    ram_wdata = value;
    if (cmd.append) begin
      ram_we = 1'b1;
    end else if (cmd.finish) begin
      ram_we    = (pos_r != last_idx);
      ram_waddr = pos_r;
      ram_wdata = last_val_r;
    end
  end

  tem_ram #(
    .WIDTH(tem_pkg::DATA_W),
    .DEPTH(tem_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  // Fill count update.
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.append) begin
      fill_nxt = fill_r + tem_pkg::fill_t'(1);
    end else if (cmd.finish) begin
      fill_nxt = fill_r - tem_pkg::fill_t'(1);
    end
  end

  // Control registers: fill count, read address and compare-valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      rd_addr_r   <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      cmp_valid_r <= cmd.rd_en;
      if (cmd.scan_start) begin
        rd_addr_r <= '0;
      end else if (cmd.rd_en) begin
        rd_addr_r <= rd_addr_r + tem_pkg::addr_t'(1);
      end
    end
  end

  // Running minimum over read data; the first slot loads unconditionally and
  // a strict compare keeps the lowest slot on ties.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      cmp_idx_r <= rd_addr_r;
    end
    if (cmp_valid_r) begin
      last_val_r <= rd_data;
      if (cmp_idx_r == '0 || rd_data < min_r) begin
        min_r <= rd_data;
        pos_r <= cmp_idx_r;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.append || cmd.rep_full || cmd.rep_empty || cmd.finish) begin
      min_value_r <= cmd.finish ? min_r : '0;
      count_r     <= tem_pkg::count_t'(fill_nxt);
      if (cmd.rep_full) begin
        status_r <= tem_pkg::ST_FULL;
      end else if (cmd.rep_empty) begin
        status_r <= tem_pkg::ST_EMPTY;
      end else begin
        status_r <= tem_pkg::ST_OK;
      end
    end
  end

  assign min_value = min_value_r;
  assign status    = status_r;
  assign count     = count_r;

endmodule
